// ===== hdl/cspc_pkg.sv =====
// Shared types, constants and a helper function of the cover strip pixel compositor.
package cspc_pkg;

   localparam int SCREEN_W        = 320;
   localparam int COVER_W         = 96;
   localparam int COVER_H         = 96;
   localparam int SIDE_COVERS_DEF = 2;
   localparam int PITCH           = 120;
   localparam int SLIDE_FRAMES    = 8;
   localparam int SLOT_COUNT      = 5;

   localparam int POS_W  = 12;
   localparam int DIFF_W = $clog2(COVER_W);
   localparam int ADDR_W = 5;

   localparam int RECIP       = 205;
   localparam int RECIP_SHIFT = 10;

   localparam logic [15:0] WHITE_RGB  = 16'hFFFF;
   localparam logic [15:0] GREY_RESET = 16'h8410;

   localparam logic [1:0] KIND_WHITE = 2'd0;
   localparam logic [1:0] KIND_GREY  = 2'd1;
   localparam logic [1:0] KIND_IMAGE = 2'd2;

   localparam logic [2:0] REG_ENTRY_COUNT   = 3'd0;
   localparam logic [2:0] REG_CENTRE_INDEX  = 3'd1;
   localparam logic [2:0] REG_FRAMES_LEFT   = 3'd2;
   localparam logic [2:0] REG_SLIDE_FORWARD = 3'd3;
   localparam logic [2:0] REG_LOADED_MASK   = 3'd4;
   localparam logic [2:0] REG_GREY_COLOUR   = 3'd5;

   typedef struct packed {
      logic [8:0] pixel_x;
      logic [6:0] pixel_y;
   } pixel_in_type;

   typedef struct packed {
      logic [1:0]  source_kind;
      logic [2:0]  slot_number;
      logic [13:0] image_offset;
      logic [15:0] fill_colour;
   } pixel_out_type;

   typedef struct packed {
      logic [10:0] entry_count;
      logic [9:0]  centre_index;
      logic [2:0]  centre_slot;
      logic [2:0]  frames_left;
      logic        slide_forward;
      logic [4:0]  loaded_mask;
      logic [15:0] grey_colour;
   } cfg_type;

   typedef struct packed {
      logic              hit;
      logic [2:0]        slot;
      logic [DIFF_W-1:0] diff;
   } lane_type;

   function automatic logic signed [POS_W-1:0] slide_shift(input logic [2:0] l,
                                                           input logic fwd);
      logic [15:0]            prod;
      logic [POS_W-1:0]       mag;
      prod = 16'(l) * 16'(l) * 16'(PITCH);
      mag  = POS_W'(prod / 16'(SLIDE_FRAMES * SLIDE_FRAMES));
      return fwd ? signed'(mag) : -signed'(mag);
   endfunction

endpackage

// ===== hdl/cspc_csr.sv =====
// Configuration register file with the APB-style access port.
module cspc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cspc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output cspc_pkg::cfg_type          cfg
);
   import cspc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic [2:0]  index;
   logic        wr_en;
   logic [17:0] quot_prod;
   logic [7:0]  quot;
   logic [9:0]  quot_x5;
   logic [2:0]  new_slot;

   assign index  = paddr[ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // The centre index is at most 1023, where multiplying by 205/1024 gives the exact quotient.
   assign quot_prod = 18'(pwdata[9:0]) * 18'(RECIP);
   assign quot      = quot_prod[RECIP_SHIFT +: 8];
   assign quot_x5   = 10'(quot) * 10'(SLOT_COUNT);
   assign new_slot  = 3'(pwdata[9:0] - quot_x5);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_ENTRY_COUNT:   cfg_in.entry_count = pwdata[10:0];
            REG_CENTRE_INDEX: begin
               cfg_in.centre_index = pwdata[9:0];
               cfg_in.centre_slot  = new_slot;
            end
            REG_FRAMES_LEFT:   cfg_in.frames_left   = pwdata[2:0];
            REG_SLIDE_FORWARD: cfg_in.slide_forward = pwdata[0];
            REG_LOADED_MASK:   cfg_in.loaded_mask   = pwdata[4:0];
            REG_GREY_COLOUR:   cfg_in.grey_colour   = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_count   <= '0;
         cfg_ff.centre_index  <= '0;
         cfg_ff.centre_slot   <= '0;
         cfg_ff.frames_left   <= '0;
         cfg_ff.slide_forward <= 1'b0;
         cfg_ff.loaded_mask   <= '0;
         cfg_ff.grey_colour   <= GREY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         REG_ENTRY_COUNT:   prdata = 32'(cfg_ff.entry_count);
         REG_CENTRE_INDEX:  prdata = 32'(cfg_ff.centre_index);
         REG_FRAMES_LEFT:   prdata = 32'(cfg_ff.frames_left);
         REG_SLIDE_FORWARD: prdata = 32'(cfg_ff.slide_forward);
         REG_LOADED_MASK:   prdata = 32'(cfg_ff.loaded_mask);
         REG_GREY_COLOUR:   prdata = 32'(cfg_ff.grey_colour);
         default:           prdata = '0;
      endcase
   end

endmodule

// ===== hdl/cspc_lane.sv =====
// Placement and hit test of the cover at one fixed offset from the centre entry.
module cspc_lane #(
   parameter int OFFSET = 0
) (
   input  cspc_pkg::cfg_type                   cfg,
   input  logic signed [cspc_pkg::POS_W-1:0]   shift,
   input  logic [8:0]                          pixel_x,
   output cspc_pkg::lane_type                  lane
);
   import cspc_pkg::*;

   localparam logic signed [POS_W-1:0] LANE_D    = POS_W'(OFFSET);
   localparam logic signed [POS_W-1:0] LANE_LEFT =
      POS_W'((SCREEN_W - COVER_W) / 2 + OFFSET * PITCH);
   localparam logic signed [4:0] SLOT_D = 5'(OFFSET);

   logic signed [POS_W-1:0] k;
   logic signed [POS_W-1:0] left;
   logic signed [POS_W-1:0] diff;
   logic signed [4:0]       slot_sum;
   logic                    k_valid;
   logic                    covered;

   assign k       = signed'(POS_W'(cfg.centre_index)) + LANE_D;
   assign k_valid = !k[POS_W-1] && (k[10:0] < cfg.entry_count);
   assign left    = LANE_LEFT + shift;
   assign diff    = signed'(POS_W'(pixel_x)) - left;
   assign covered = !diff[POS_W-1] && (diff < POS_W'(COVER_W));

   assign slot_sum = signed'(5'(cfg.centre_slot)) + SLOT_D;

   always_comb begin
      lane.hit  = k_valid && covered;
      lane.diff = diff[DIFF_W-1:0];
      if (slot_sum < 0) begin
         lane.slot = 3'(slot_sum + 5'(SLOT_COUNT));
      end else if (slot_sum >= 5'(SLOT_COUNT)) begin
         lane.slot = 3'(slot_sum - 5'(SLOT_COUNT));
      end else begin
         lane.slot = 3'(slot_sum);
      end
   end

endmodule

// ===== hdl/cover_strip_pixel_compositor_top.sv =====
// Top level of the cover strip pixel compositor: input register, cover lanes, result register.
//
// Usage: configure the strip through the APB-style port (psel, penable, pwrite,
// paddr, pwdata, prdata, pready) while no pixel is in flight; register i sits at
// byte address 4*i and pready is always high.
// A pixel word (req_word) is taken at each rising edge with start high and busy
// low. busy is always low, so one pixel can be taken every cycle.
// The result word appears on rsp_word right after the next rising edge, with
// rsp_strobe high for exactly that one cycle; there is no back pressure, so the
// receiver must take every word as it comes.
// Throughput is one pixel per cycle; the path between the input register and
// the result register holds the placement adders and compares of each cover
// lane, a small multiplier for the row offset and the priority select over the lanes.
// Reset clears the pipeline valid flags and returns the configuration registers to
// their defaults; words in flight at reset are dropped.
module cover_strip_pixel_compositor_top #(
   parameter int SIDE_COVERS = cspc_pkg::SIDE_COVERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  cspc_pkg::pixel_in_type      req_word,
   output logic                        rsp_strobe,
   output cspc_pkg::pixel_out_type     rsp_word,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cspc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import cspc_pkg::*;

   localparam int LANES = 2 * SIDE_COVERS + 1;

   cfg_type                 cfg;
   logic                    in_valid_ff, in_valid_in;
   pixel_in_type            in_pix_ff, in_pix_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pixel_out_type           rsp_word_ff, rsp_word_in;
   logic signed [POS_W-1:0] shift;
   lane_type                lanes [LANES];
   logic                    in_range;
   logic                    any_hit;
   logic [2:0]              win_slot;
   logic [DIFF_W-1:0]       win_diff;
   logic [13:0]             row_base;

   cspc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;
   assign in_pix_in   = start ? req_word : in_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_pix_ff <= in_pix_in;
   end

   assign shift = slide_shift(cfg.frames_left, cfg.slide_forward);

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      cspc_lane #(
         .OFFSET (j - SIDE_COVERS)
      ) u_lane (
         .cfg     (cfg),
         .shift   (shift),
         .pixel_x (in_pix_ff.pixel_x),
         .lane    (lanes[j])
      );
   end

   assign in_range = (10'(in_pix_ff.pixel_x) < 10'(SCREEN_W)) &&
                     (9'(in_pix_ff.pixel_y) < 9'(COVER_H));

   // Later lanes hold higher entry indices and take priority.
   always_comb begin
      any_hit  = 1'b0;
      win_slot = '0;
      win_diff = '0;
      for (int j = 0; j < LANES; j++) begin
         if (lanes[j].hit) begin
            any_hit  = 1'b1;
            win_slot = lanes[j].slot;
            win_diff = lanes[j].diff;
         end
      end
   end

   assign row_base = 14'(in_pix_ff.pixel_y) * 14'(COVER_W);

   always_comb begin
      rsp_word_in = '0;
      if (!(any_hit && in_range)) begin
         rsp_word_in.source_kind = KIND_WHITE;
         rsp_word_in.fill_colour = WHITE_RGB;
      end else if (cfg.loaded_mask[win_slot]) begin
         rsp_word_in.source_kind  = KIND_IMAGE;
         rsp_word_in.slot_number  = win_slot;
         rsp_word_in.image_offset = row_base + 14'(win_diff);
      end else begin
         rsp_word_in.source_kind = KIND_GREY;
         rsp_word_in.slot_number = win_slot;
         rsp_word_in.fill_colour = cfg.grey_colour;
      end
   end

   assign rsp_valid_in = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

`ifndef SYNTHESIS
   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("Result word without an accepted pixel two cycles earlier.");

   a_no_strobe_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_strobe)
      else $error("Result strobe right after reset.");

   a_white_word_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.source_kind == KIND_WHITE) |->
         (rsp_word.slot_number == 3'd0 && rsp_word.image_offset == 14'd0 &&
          rsp_word.fill_colour == WHITE_RGB))
      else $error("White result word carries cover data.");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.slot_number < 3'(SLOT_COUNT)))
      else $error("Slot number out of range.");
`endif

endmodule

// ===== verif/tb_cover_strip_pixel_compositor_top.sv =====
// Self-checking testbench for the cover strip pixel compositor top level.
module tb_cover_strip_pixel_compositor_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cspc_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_PHASES = 26;
   localparam int PHASE_ITEMS   = 50;

   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;

   logic              clock   = 1'b0;
   logic              reset   = 1'b1;
   logic              start   = 1'b0;
   logic              busy;
   pixel_in_type      req_word = '0;
   logic              rsp_strobe;
   pixel_out_type     rsp_word;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [31:0]       pwdata  = '0;
   logic [31:0]       prdata;
   logic              pready;

   logic [10:0] cfg_entry_count   = '0;
   logic [9:0]  cfg_centre_index  = '0;
   logic [2:0]  cfg_frames_left   = '0;
   logic        cfg_slide_forward = 1'b0;
   logic [4:0]  cfg_loaded_mask   = '0;
   logic [15:0] cfg_grey_colour   = GREY_RESET;

   pixel_in_type  pixel_backlog[$];
   pixel_out_type predicted_pixels[$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int burst_left     = 0;
   int gap_left       = 0;

   cover_strip_pixel_compositor_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #5 clock = ~clock;

   function automatic pixel_out_type compose_pixel(input pixel_in_type pix);
      pixel_out_type res;
      int px, py, count, centre, frames, mag, shift, base, left, hit_k, hit_left;
      bit hit;
      px       = int'(pix.pixel_x);
      py       = int'(pix.pixel_y);
      count    = int'(cfg_entry_count);
      centre   = int'(cfg_centre_index);
      frames   = int'(cfg_frames_left);
      mag      = (PITCH * frames * frames) / (SLIDE_FRAMES * SLIDE_FRAMES);
      shift    = cfg_slide_forward ? mag : -mag;
      base     = (SCREEN_W - COVER_W) / 2;
      hit      = 1'b0;
      hit_k    = 0;
      hit_left = 0;
      if (px < SCREEN_W && py < COVER_H) begin
         for (int k = centre - SIDE_COVERS_DEF; k <= centre + SIDE_COVERS_DEF; k++) begin
            if (k >= 0 && k < count) begin
               left = base + (k - centre) * PITCH + shift;
               if (px >= left && px < left + COVER_W) begin
                  hit      = 1'b1;
                  hit_k    = k;
                  hit_left = left;
               end
            end
         end
      end
      res = '0;
      if (!hit) begin
         res.source_kind = KIND_WHITE;
         res.fill_colour = WHITE_RGB;
      end else begin
         res.slot_number = 3'(hit_k % SLOT_COUNT);
         if (cfg_loaded_mask[hit_k % SLOT_COUNT]) begin
            res.source_kind  = KIND_IMAGE;
            res.image_offset = 14'(py * COVER_W + px - hit_left);
         end else begin
            res.source_kind = KIND_GREY;
            res.fill_colour = cfg_grey_colour;
         end
      end
      return res;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ENTRY_COUNT:   cfg_entry_count   = value[10:0];
         REG_CENTRE_INDEX:  cfg_centre_index  = value[9:0];
         REG_FRAMES_LEFT:   cfg_frames_left   = value[2:0];
         REG_SLIDE_FORWARD: cfg_slide_forward = value[0];
         REG_LOADED_MASK:   cfg_loaded_mask   = value[4:0];
         REG_GREY_COLOUR:   cfg_grey_colour   = value[15:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [10:0] count, input logic [9:0] centre,
                            input logic [2:0] frames, input logic fwd,
                            input logic [4:0] mask, input logic [15:0] grey,
                            input bit noisy);
      logic [31:0] junk;
      junk = noisy ? 32'($urandom) : 32'd0;
      csr_write(REG_ENTRY_COUNT, {junk[31:11], count});
      csr_write(REG_CENTRE_INDEX, {junk[31:10], centre});
      csr_write(REG_FRAMES_LEFT, {junk[31:3], frames});
      csr_write(REG_SLIDE_FORWARD, {junk[31:1], fwd});
      csr_write(REG_LOADED_MASK, {junk[31:5], mask});
      csr_write(REG_GREY_COLOUR, {junk[31:16], grey});
   endtask

   task automatic queue_pixel(input int x, input int y);
      pixel_in_type pix;
      pix.pixel_x = 9'(x);
      pix.pixel_y = 7'(y);
      pixel_backlog.push_back(pix);
   endtask

   task automatic drain();
      while (pixel_backlog.size() != 0 || start || predicted_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic next_start;
      if (reset) begin
         start      <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            predicted_pixels.push_back(compose_pixel(req_word));
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pixel_backlog.size() != 0) begin
               req_word <= pixel_backlog.pop_front();
               next_start = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_pixels.size() == 0) begin
            $error("result word %h arrived with nothing outstanding", rsp_word);
            mismatch_count++;
         end else begin
            want = predicted_pixels.pop_front();
            if (rsp_word.source_kind !== want.source_kind) begin
               $error("source_kind expected %0d actual %0d", want.source_kind,
                      rsp_word.source_kind);
               mismatch_count++;
            end
            if (rsp_word.slot_number !== want.slot_number) begin
               $error("slot_number expected %0d actual %0d", want.slot_number,
                      rsp_word.slot_number);
               mismatch_count++;
            end
            if (rsp_word.image_offset !== want.image_offset) begin
               $error("image_offset expected %0d actual %0d", want.image_offset,
                      rsp_word.image_offset);
               mismatch_count++;
            end
            if (rsp_word.fill_colour !== want.fill_colour) begin
               $error("fill_colour expected %h actual %h", want.fill_colour,
                      rsp_word.fill_colour);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL cover_strip_pixel_compositor_top");
            $finish;
         end
      end
   end

   initial begin
      logic [10:0] count;
      logic [9:0]  centre;
      logic [15:0] grey;
      int          sel;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty list after reset: every pixel is white.
      queue_pixel(0, 0);
      queue_pixel(319, 95);
      queue_pixel(160, 48);
      drain();

      configure(11'd1024, 10'd2, 3'd0, 1'b0, 5'b10101, 16'h1234, 1'b0);
      queue_pixel(112, 0);
      queue_pixel(207, 95);
      queue_pixel(0, 0);
      queue_pixel(100, 10);
      queue_pixel(232, 50);
      queue_pixel(320, 0);
      queue_pixel(511, 127);
      queue_pixel(150, 96);
      queue_pixel(150, 127);
      drain();

      configure(11'd2047, 10'd1023, 3'd7, 1'b1, 5'b11111, 16'h0000, 1'b1);
      queue_pixel(0, 0);
      queue_pixel(203, 0);
      queue_pixel(298, 95);
      queue_pixel(319, 50);
      drain();

      // Centre beyond the end of the list.
      configure(11'd9, 10'd10, 3'd3, 1'b1, 5'b00000, 16'hFFFF, 1'b0);
      queue_pixel(8, 5);
      queue_pixel(103, 5);
      queue_pixel(7, 5);
      queue_pixel(200, 5);
      drain();

      configure(11'd1, 10'd0, 3'd7, 1'b0, 5'b00001, GREY_RESET, 1'b0);
      csr_write(REG_SPARE_A, 32'($urandom));
      csr_write(REG_SPARE_B, 32'($urandom));
      queue_pixel(21, 0);
      queue_pixel(116, 95);
      queue_pixel(20, 0);
      queue_pixel(117, 0);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         sel = $urandom_range(0, 3);
         case (sel)
            0:       centre = 10'd0;
            1:       centre = 10'd1023;
            2:       centre = 10'($urandom_range(0, 6));
            default: centre = 10'($urandom_range(0, 1023));
         endcase
         sel = $urandom_range(0, 9);
         case (sel)
            0:       count = 11'd0;
            1:       count = 11'd1024;
            2:       count = 11'd2047;
            3:       count = 11'($urandom_range(0, 2047));
            default: count = 11'(int'(centre) + $urandom_range(0, 4));
         endcase
         sel = $urandom_range(0, 5);
         case (sel)
            0:       grey = 16'h0000;
            1:       grey = 16'hFFFF;
            default: grey = 16'($urandom);
         endcase
         configure(count, centre, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   5'($urandom_range(0, 31)), grey, $urandom_range(0, 1) == 1);
         if ($urandom_range(0, 4) == 0)
            csr_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 32'($urandom));
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 6) == 0)
               queue_pixel($urandom_range(0, 511), $urandom_range(0, 127));
            else
               queue_pixel($urandom_range(0, SCREEN_W - 1), $urandom_range(0, COVER_H - 1));
         end
         drain();
      end

      if (mismatch_count == 0 && predicted_pixels.size() == 0)
         $display("PASS cover_strip_pixel_compositor_top");
      else
         $display("FAIL cover_strip_pixel_compositor_top");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/cspc_pkg.sv
hdl/cspc_csr.sv
hdl/cspc_lane.sv
hdl/cover_strip_pixel_compositor_top.sv
verif/tb_cover_strip_pixel_compositor_top.sv
